FILE: sv/psfp_pkg.sv
// ----------------------------------------------------------------------------
// Particle sensor frame parser package
// Start bytes and frame status codes shared by the parser and its users.
// ----------------------------------------------------------------------------
package psfp_pkg;

    localparam logic [7:0] START_FIRST  = 8'h42;
    localparam logic [7:0] START_SECOND = 8'h4D;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_GOOD    = 2'd0;
    localparam status_t STATUS_BAD_SUM = 2'd1;
    localparam status_t STATUS_BAD_LEN = 2'd2;

endpackage

FILE: sv/particle_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// Particle sensor frame parser
// Hunts for the start pair, collects the length word and six PM words, checks
// the frame checksum and delivers one result per finished frame or bad length.
// The result is in the output register in the cycle after the last byte is accepted.
// Throughput: one byte per cycle; in_ready falls only while a result is held
// and out_ready is low, since a single output register holds one result.
// Reset: rst_n clears the parser to hunting and empties the output register.
// ----------------------------------------------------------------------------
module particle_sensor_frame_parser #(
    parameter int MAX_FRAME_BYTES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       pm1_standard,
    output logic [15:0]       pm25_standard,
    output logic [15:0]       pm10_standard,
    output logic [15:0]       pm1_atmospheric,
    output logic [15:0]       pm25_atmospheric,
    output logic [15:0]       pm10_atmospheric,
    output logic [15:0]       declared_length,
    output psfp_pkg::status_t frame_status
);

    import psfp_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = POS_W + 2;

    logic             synced_reg, synced_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] frame_end_reg, frame_end_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       prev_reg;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      pm_reg [6];
    logic             pm_clear, pm_wr;
    logic [2:0]       pm_idx;

    logic             out_valid_reg, out_valid_next;
    logic [15:0]      res_pm_reg [6];
    logic [15:0]      res_len_reg;
    status_t          res_status_reg;

    logic             accept;
    logic             emit;
    status_t          emit_status;
    logic [CMP_W-1:0] p_ext, np, fe_ext;
    logic [15:0]      w;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign p_ext  = CMP_W'(pos_reg);
    assign np     = p_ext + CMP_W'(1);
    assign fe_ext = CMP_W'(frame_end_reg);
    assign w      = {prev_reg, rx_byte};
    assign pm_idx = 3'((np - CMP_W'(4)) >> 1);

    always_comb
    begin
        synced_next    = synced_reg;
        pos_next       = pos_reg;
        frame_end_next = frame_end_reg;
        sum_next       = sum_reg;
        len_next       = len_reg;
        pm_clear       = 1'b0;
        pm_wr          = 1'b0;
        emit           = 1'b0;
        emit_status    = STATUS_GOOD;
        if (!synced_reg)
        begin
            if (pos_reg == POS_W'(1) && rx_byte == START_SECOND)
            begin
                synced_next = 1'b1;
                pos_next    = POS_W'(2);
                sum_next    = sum_reg + 16'(rx_byte);
            end
            else if (rx_byte == START_FIRST)
            begin
                pos_next       = POS_W'(1);
                sum_next       = 16'(rx_byte);
                frame_end_next = POS_W'(MAX_FRAME_BYTES);
                len_next       = 16'd0;
                pm_clear       = 1'b1;
            end
            else
            begin
                pos_next = '0;
            end
        end
        else
        begin
            if (p_ext + CMP_W'(2) < fe_ext)
            begin
                sum_next = sum_reg + 16'(rx_byte);
            end
            pos_next = POS_W'(np);
            if (np == CMP_W'(4))
            begin
                len_next = w;
                if (w < 16'd2 || w > 16'(MAX_FRAME_BYTES - 4))
                begin
                    emit        = 1'b1;
                    emit_status = STATUS_BAD_LEN;
                end
                else
                begin
                    frame_end_next = POS_W'(w + 16'd4);
                end
            end
            else if (np >= CMP_W'(6) && np <= CMP_W'(16) && !np[0]
                     && np + CMP_W'(2) <= fe_ext)
            begin
                pm_wr = 1'b1;
            end
            if (!emit && np >= fe_ext)
            begin
                emit        = 1'b1;
                emit_status = (sum_next == w) ? STATUS_GOOD : STATUS_BAD_SUM;
            end
            if (emit)
            begin
                synced_next = 1'b0;
                pos_next    = '0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            synced_reg    <= 1'b0;
            pos_reg       <= '0;
            frame_end_reg <= POS_W'(MAX_FRAME_BYTES);
            sum_reg       <= '0;
            prev_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                synced_reg    <= synced_next;
                pos_reg       <= pos_next;
                frame_end_reg <= frame_end_next;
                sum_reg       <= sum_next;
                prev_reg      <= rx_byte;
                len_reg       <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 6; k++)
            begin
                if (pm_clear)
                begin
                    pm_reg[k] <= '0;
                end
                else if (pm_wr && pm_idx == 3'(k + 1))
                begin
                    pm_reg[k] <= w;
                end
            end
            if (emit)
            begin
                for (int k = 0; k < 6; k++)
                begin
                    res_pm_reg[k] <= (pm_wr && pm_idx == 3'(k + 1)) ? w : pm_reg[k];
                end
                res_len_reg    <= len_next;
                res_status_reg <= emit_status;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign pm1_standard     = res_pm_reg[0];
    assign pm25_standard    = res_pm_reg[1];
    assign pm10_standard    = res_pm_reg[2];
    assign pm1_atmospheric  = res_pm_reg[3];
    assign pm25_atmospheric = res_pm_reg[4];
    assign pm10_atmospheric = res_pm_reg[5];
    assign declared_length  = res_len_reg;
    assign frame_status     = res_status_reg;

    // While hunting the parser has seen at most the first start byte.
    a_hunt_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !synced_reg |-> pos_reg <= POS_W'(1))
        else $error("hunting position beyond first start byte");

    a_sync_pos: assert property (@(posedge clk) disable iff (!rst_n)
        synced_reg |-> pos_reg >= POS_W'(2) && pos_reg < frame_end_reg)
        else $error("synced position outside frame");

    a_end_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end_reg <= POS_W'(MAX_FRAME_BYTES) && frame_end_reg >= POS_W'(6))
        else $error("frame end out of range");

    a_len_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_status_reg == STATUS_BAD_LEN |->
            res_pm_reg[0] == 16'd0 && res_pm_reg[5] == 16'd0)
        else $error("length error result carries PM data");

    a_emit_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit |=> !synced_reg && pos_reg == '0)
        else $error("parser not hunting after a result");

endmodule
